### design/sapb_pkg.sv
package sapb_pkg;

  // largest atlas side; width of the dimension registers follows the field widths
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned PIXEL_BITS = 32;
  localparam int unsigned QueueDepth = 4;

  localparam logic [12:0] MaxDim    = 13'(MAX_DIM);
  localparam logic [31:0] PixelCap  = 32'((64'd1 << PIXEL_BITS) - 64'd1);

  // input opcodes carried in tuser
  localparam logic [1:0] OpPlace = 2'd0;
  localparam logic [1:0] OpPixel = 2'd1;
  localparam logic [1:0] OpReset = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] RegAtlasWidth  = 2'd0;
  localparam logic [1:0] RegAtlasHeight = 2'd1;
  localparam logic [1:0] RegBytes       = 2'd2;
  localparam logic [1:0] RegEdgeMode    = 2'd3;

  // edge modes
  localparam logic [1:0] EdgeNone  = 2'd0;
  localparam logic [1:0] EdgeClear = 2'd1;
  localparam logic [1:0] EdgeHard  = 2'd2;
  localparam logic [1:0] EdgeBoth  = 2'd3;

  // settings seen by the front and the back, already clamped
  typedef struct packed {
    logic [12:0] aw;
    logic [12:0] ah;
    logic        gutter;
    logic        hard;
    logic [31:0] data_mask;
  } cfg_t;

  // one queued job: a placement answer or one pixel with its write mask
  typedef struct packed {
    logic        is_pixel;
    logic        placed;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [8:0]  mask;      // bit 3*row+col of the 3x3 neighborhood
    logic [12:0] col0;
    logic [12:0] row0;
    logic [31:0] data;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic        placed;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [23:0] write_index;
    logic [31:0] write_data;
    logic        last;
  } res_t;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [31:0] pixel_mask(input logic [2:0] bpp);
    logic [31:0] m;
    case (bpp)
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd0,
      3'd1:    m = 32'h0000_00FF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m & PixelCap;
  endfunction

endpackage

### design/sapb_front.sv
module sapb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [12:0]       rect_width_i,
  input  logic [12:0]       rect_height_i,
  input  logic [31:0]       pixel_data_i,
  input  sapb_pkg::cfg_t    cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output sapb_pkg::job_t    job_o
);
  import sapb_pkg::*;

  logic [12:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [12:0] row_height_q, row_height_d;
  logic [11:0] slot_x_q, slot_x_d, slot_y_q, slot_y_d;
  logic [12:0] slot_w_q, slot_w_d, slot_h_q, slot_h_d;
  logic [12:0] pixel_col_q, pixel_col_d, pixel_row_q, pixel_row_d;
  logic        slot_active_q, slot_active_d;

  logic        accept;
  logic [13:0] ow, oh, gpad;
  logic [14:0] aw15, ah15, next_y;
  logic        fit_size, fit_x, fit_y, fit_next, place_ok, same_row;
  logic [12:0] px, py;
  logic [13:0] c0, r0, aw14, ah14;
  logic        at_left, at_right, at_top, at_bottom;
  logic [2:0]  col_ok, row_ok;
  logic [8:0]  mask;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // placement
  always_comb begin
    gpad     = cfg_i.gutter ? 14'd2 : 14'd0;
    ow       = {1'b0, rect_width_i} + gpad;
    oh       = {1'b0, rect_height_i} + gpad;
    aw15     = {2'b0, cfg_i.aw};
    ah15     = {2'b0, cfg_i.ah};
    next_y   = {2'b0, cursor_y_q} + {2'b0, row_height_q};
    fit_size = ({1'b0, ow} <= aw15) && ({1'b0, oh} <= ah15);
    fit_x    = ({2'b0, cursor_x_q} + {1'b0, ow}) <= aw15;
    fit_y    = ({2'b0, cursor_y_q} + {1'b0, oh}) <= ah15;
    fit_next = (next_y + {1'b0, oh}) <= ah15;
    same_row = fit_x;
    place_ok = fit_size && (fit_x ? fit_y : fit_next);
    if (same_row) begin
      px = cursor_x_q + {12'b0, cfg_i.gutter};
      py = cursor_y_q + {12'b0, cfg_i.gutter};
    end else begin
      px = {12'b0, cfg_i.gutter};
      py = next_y[12:0] + {12'b0, cfg_i.gutter};
    end
  end

  // neighborhood of the current pixel
  always_comb begin
    c0        = {2'b0, slot_x_q} + {1'b0, pixel_col_q};
    r0        = {2'b0, slot_y_q} + {1'b0, pixel_row_q};
    aw14      = {1'b0, cfg_i.aw};
    ah14      = {1'b0, cfg_i.ah};
    at_left   = cfg_i.hard && (pixel_col_q == 13'd0);
    at_top    = cfg_i.hard && (pixel_row_q == 13'd0);
    at_right  = cfg_i.hard && (({1'b0, pixel_col_q} + 14'd1) == {1'b0, slot_w_q});
    at_bottom = cfg_i.hard && (({1'b0, pixel_row_q} + 14'd1) == {1'b0, slot_h_q});
    col_ok[0] = at_left && (c0 != 14'd0) && ((c0 - 14'd1) < aw14);
    col_ok[1] = c0 < aw14;
    col_ok[2] = at_right && ((c0 + 14'd1) < aw14);
    row_ok[0] = at_top && (r0 != 14'd0) && ((r0 - 14'd1) < ah14);
    row_ok[1] = r0 < ah14;
    row_ok[2] = at_bottom && ((r0 + 14'd1) < ah14);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask[3*i+j] = row_ok[i] && col_ok[j];
      end
    end
  end

  always_comb begin
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    row_height_d  = row_height_q;
    slot_x_d      = slot_x_q;
    slot_y_d      = slot_y_q;
    slot_w_d      = slot_w_q;
    slot_h_d      = slot_h_q;
    pixel_col_d   = pixel_col_q;
    pixel_row_d   = pixel_row_q;
    slot_active_d = slot_active_q;
    push_o        = 1'b0;
    job_o         = '0;
    if (accept) begin
      unique case (opcode_i)
        OpPlace: begin
          push_o         = 1'b1;
          job_o.placed   = place_ok;
          slot_active_d  = 1'b0;
          if (place_ok) begin
            job_o.pos_x   = px[11:0];
            job_o.pos_y   = py[11:0];
            slot_x_d      = px[11:0];
            slot_y_d      = py[11:0];
            slot_w_d      = rect_width_i;
            slot_h_d      = rect_height_i;
            pixel_col_d   = '0;
            pixel_row_d   = '0;
            slot_active_d = (rect_width_i != 13'd0) && (rect_height_i != 13'd0);
            if (same_row) begin
              cursor_x_d = cursor_x_q + ow[12:0];
              if ({1'b0, row_height_q} < oh) begin
                row_height_d = oh[12:0];
              end
            end else begin
              cursor_y_d   = next_y[12:0];
              cursor_x_d   = ow[12:0];
              row_height_d = oh[12:0];
            end
          end
        end
        OpPixel: begin
          if (slot_active_q) begin
            push_o         = mask != 9'd0;
            job_o.is_pixel = 1'b1;
            job_o.mask     = mask;
            job_o.col0     = c0[12:0];
            job_o.row0     = r0[12:0];
            job_o.data     = pixel_data_i & cfg_i.data_mask;
            if (({1'b0, pixel_col_q} + 14'd1) >= {1'b0, slot_w_q}) begin
              pixel_col_d = '0;
              pixel_row_d = pixel_row_q + 13'd1;
              if (({1'b0, pixel_row_q} + 14'd1) >= {1'b0, slot_h_q}) begin
                slot_active_d = 1'b0;
              end
            end else begin
              pixel_col_d = pixel_col_q + 13'd1;
            end
          end
        end
        OpReset: begin
          cursor_x_d    = '0;
          cursor_y_d    = '0;
          row_height_d  = '0;
          slot_active_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      row_height_q  <= '0;
      slot_x_q      <= '0;
      slot_y_q      <= '0;
      slot_w_q      <= '0;
      slot_h_q      <= '0;
      pixel_col_q   <= '0;
      pixel_row_q   <= '0;
      slot_active_q <= 1'b0;
    end else begin
      cursor_x_q    <= cursor_x_d;
      cursor_y_q    <= cursor_y_d;
      row_height_q  <= row_height_d;
      slot_x_q      <= slot_x_d;
      slot_y_q      <= slot_y_d;
      slot_w_q      <= slot_w_d;
      slot_h_q      <= slot_h_d;
      pixel_col_q   <= pixel_col_d;
      pixel_row_q   <= pixel_row_d;
      slot_active_q <= slot_active_d;
    end
  end

endmodule

### design/sapb_queue.sv
module sapb_queue #(
  parameter int unsigned DEPTH = sapb_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sapb_pkg::job_t data_i,
  input  logic           pop_i,
  output sapb_pkg::job_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import sapb_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = count_q == CntW'(0);
  assign full_o  = count_q == CntW'(DEPTH);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // the front must hold off while the queue is full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count overflow");

endmodule

### design/sapb_back.sv
module sapb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sapb_pkg::cfg_t cfg_i,
  input  sapb_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sapb_pkg::res_t out_o
);
  import sapb_pkg::*;

  typedef struct packed {
    logic        kind;
    logic        placed;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] data;
    logic        last;
  } mid_t;

  logic        started_q, started_d;
  logic [8:0]  rem_q, rem_d;
  logic        mid_v_q, mid_v_d;
  mid_t        mid_q, mid_d;
  logic        out_v_q, out_v_d;
  res_t        out_q;

  logic        mid_ready, walk_ready, fire, is_last;
  logic [8:0]  cur_mask, pick, rest;
  logic [1:0]  drow, dcol;
  logic [13:0] rsum, csum;
  logic [24:0] index_full;

  assign mid_ready  = !out_v_q || out_ready_i;
  assign walk_ready = !mid_v_q || mid_ready;
  assign fire       = !empty_i && walk_ready;

  // walk the set bits of the neighborhood mask, lowest first
  always_comb begin
    cur_mask = started_q ? rem_q : head_i.mask;
    pick     = cur_mask & (~cur_mask + 9'd1);
    rest     = cur_mask & ~pick;
    is_last  = head_i.is_pixel ? (rest == 9'd0) : 1'b1;
    case (pick)
      9'b000000001: begin drow = 2'd0; dcol = 2'd0; end
      9'b000000010: begin drow = 2'd0; dcol = 2'd1; end
      9'b000000100: begin drow = 2'd0; dcol = 2'd2; end
      9'b000001000: begin drow = 2'd1; dcol = 2'd0; end
      9'b000100000: begin drow = 2'd1; dcol = 2'd2; end
      9'b001000000: begin drow = 2'd2; dcol = 2'd0; end
      9'b010000000: begin drow = 2'd2; dcol = 2'd1; end
      9'b100000000: begin drow = 2'd2; dcol = 2'd2; end
      default:      begin drow = 2'd1; dcol = 2'd1; end
    endcase
    rsum = {1'b0, head_i.row0} + {12'b0, drow} - 14'd1;
    csum = {1'b0, head_i.col0} + {12'b0, dcol} - 14'd1;
  end

  always_comb begin
    pop_o     = fire && is_last;
    started_d = started_q;
    rem_d     = rem_q;
    if (fire) begin
      started_d = !is_last;
      rem_d     = rest;
    end
    mid_v_d = walk_ready ? fire : mid_v_q;
    mid_d        = '0;
    mid_d.kind   = head_i.is_pixel;
    mid_d.last   = is_last;
    if (head_i.is_pixel) begin
      mid_d.row  = rsum[11:0];
      mid_d.col  = csum[11:0];
      mid_d.data = head_i.data;
    end else begin
      mid_d.placed = head_i.placed;
      mid_d.pos_x  = head_i.pos_x;
      mid_d.pos_y  = head_i.pos_y;
    end
    out_v_d    = mid_ready ? mid_v_q : out_v_q;
    index_full = 25'(mid_q.row) * 25'(cfg_i.aw) + 25'(mid_q.col);
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mid_q <= mid_d;
    end
    if (mid_v_q && mid_ready) begin
      out_q.kind        <= mid_q.kind;
      out_q.placed      <= mid_q.placed;
      out_q.pos_x       <= mid_q.pos_x;
      out_q.pos_y       <= mid_q.pos_y;
      out_q.write_index <= index_full[23:0];
      out_q.write_data  <= mid_q.data;
      out_q.last        <= mid_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rem_q     <= '0;
      mid_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      rem_q     <= rem_d;
      mid_v_q   <= mid_v_d;
      out_v_q   <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // a job stays at the queue head until its last write has left the walker
  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> !empty_i && head_i.is_pixel)
    else $error("walker lost its queue head");

  a_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.kind |-> out_q.last && out_q.write_index == 24'd0)
    else $error("placement answer malformed");

  a_write_unplaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.kind |-> !out_q.placed && out_q.pos_x == 12'd0
      && out_q.pos_y == 12'd0)
    else $error("atlas write carries placement fields");

endmodule

### design/shelf_atlas_packer_blit.sv
// Shelf atlas packer with a streaming blit. An input item with opcode 0 asks for a
// rectangle; the block places it on the current shelf (or opens the next shelf),
// leaving a one-pixel gutter when edge_mode is nonzero, and returns one answer item
// with placed and the inner top-left corner. The rectangle's pixels then follow with
// opcode 1, row by row, and each becomes atlas write items (row * atlas_width +
// column); in hard edge mode a border pixel is also copied into its gutter
// neighbors, up to nine writes for a 1x1 rectangle. Opcode 2 returns the cursor to
// the origin. Writes outside the atlas are dropped, so a pixel can give no item.
// Timing: a place or interior pixel is taken every cycle unless the queue is full.
// Results pass the walker stage, then the index multiply stage; the walker emits
// one write per cycle unless the output stalls, so the QUEUE_DEPTH-entry job queue
// absorbs multi-write pixels until it fills. Configuration writes are taken whenever
// cfg_we_i is high and must only occur with the block idle.
module shelf_atlas_packer_blit #(
  parameter int unsigned QUEUE_DEPTH = sapb_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // rect_width, rect_height, pixel_data, zero pad
  input  logic [1:0]  s_axis_tuser_i,   // opcode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // placed, pos_x, pos_y, write_index,
                                        // write_data, zero pad
  output logic [0:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);
  import sapb_pkg::*;

  // configuration registers
  logic [12:0] atlas_width_q, atlas_height_q;
  logic [2:0]  bytes_per_pixel_q;
  logic [1:0]  edge_mode_q;
  cfg_t        cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q     <= 13'd256;
      atlas_height_q    <= 13'd256;
      bytes_per_pixel_q <= 3'd4;
      edge_mode_q       <= EdgeNone;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegAtlasWidth:  atlas_width_q     <= cfg_data_i;
        RegAtlasHeight: atlas_height_q    <= cfg_data_i;
        RegBytes:       bytes_per_pixel_q <= cfg_data_i[2:0];
        RegEdgeMode:    edge_mode_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // clamped view of the settings; edge mode three behaves as hard
  always_comb begin
    cfg.aw        = clamp_dim(atlas_width_q);
    cfg.ah        = clamp_dim(atlas_height_q);
    cfg.gutter    = edge_mode_q != EdgeNone;
    cfg.hard      = edge_mode_q[1];
    cfg.data_mask = pixel_mask(bytes_per_pixel_q);
  end

  logic  push, pop, q_empty, q_full, out_valid;
  job_t  push_job, head_job;
  res_t  res;

  // front: classifies items, owns the shelf cursor and slot counters
  sapb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i),
    .rect_width_i  (s_axis_tdata_i[12:0]),
    .rect_height_i (s_axis_tdata_i[25:13]),
    .pixel_data_i  (s_axis_tdata_i[57:26]),
    .cfg_i         (cfg),
    .full_i        (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // job queue between the two halves
  sapb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: expands each job into result items
  sapb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {7'b0, res.write_data, res.write_index, res.pos_y, res.pos_x,
                            res.placed};
  assign m_axis_tuser_o  = res.kind;
  assign m_axis_tlast_o  = res.last;

endmodule

### verif/tb.sv
module tb;
  import sapb_pkg::*;

  // spare cycles after the last owed result before a register write
  localparam int DrainGap   = 64;
  // cycles with no handshake and no register write before the run is called hung
  localparam int StallLimit = 5000;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 32;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_index_i     = 2'd0;
  logic [12:0] cfg_data_i      = 13'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = 64'd0;  // rect_width, rect_height, pixel_data, zero pad
  logic [1:0]  s_axis_tuser_i  = 2'd0;   // opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;           // placed, pos_x, pos_y, write_index,
                                         // write_data, zero pad
  logic [0:0]  m_axis_tuser_o;           // kind
  logic        m_axis_tlast_o;

  shelf_atlas_packer_blit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // packer shadow: registers as written, shelf cursor and the open slot
  // ---------------------------------------------------------------------------
  logic [12:0] shadow_aw   = 13'd256;
  logic [12:0] shadow_ah   = 13'd256;
  logic [2:0]  shadow_bpp  = 3'd4;
  logic [1:0]  shadow_edge = EdgeNone;

  logic [12:0] cur_x   = '0;
  logic [12:0] cur_y   = '0;
  logic [12:0] shelf_h = '0;
  logic [11:0] slot_x  = '0;
  logic [11:0] slot_y  = '0;
  logic [12:0] slot_w  = '0;
  logic [12:0] slot_h  = '0;
  logic [12:0] col_n   = '0;
  logic [12:0] row_n   = '0;
  logic        slot_on = 1'b0;

  // answers and atlas writes still owed by the block, oldest first
  res_t owed_results[$];

  int idle_pct   = 31;   // chance in a hundred that either side idles this cycle
  int n_err      = 0;
  int n_in       = 0;
  int n_out      = 0;
  int work_items = 0;    // items that move the cursor or feed an open slot
  bit in_flight  = 1'b0; // items sent since the block was last seen idle

  function automatic int clamped(logic [12:0] v);
    if (v == 13'd0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // works out what one accepted input item must produce and queues it
  task automatic shelf_predict(input logic [1:0] op, input logic [12:0] w, h,
                               input logic [31:0] pix);
    int          aw, ah, e, ow, oh, px, py, c0, r0, c, r, n, bpp;
    bit          fits, hard;
    logic [31:0] keep;
    res_t        one;
    aw = clamped(shadow_aw);
    ah = clamped(shadow_ah);
    one = '0;
    case (op)
      OpPlace: begin
        work_items++;
        e = (shadow_edge != EdgeNone) ? 1 : 0;
        ow = int'(w) + 2 * e;
        oh = int'(h) + 2 * e;
        fits = 1'b0;
        px = 0;
        py = 0;
        slot_on = 1'b0;  // a new request drops any half-streamed slot
        if (ow <= aw && oh <= ah) begin
          if (int'(cur_x) + ow <= aw) begin
            if (int'(cur_y) + oh <= ah) begin
              px = int'(cur_x) + e;
              py = int'(cur_y) + e;
              cur_x = 13'(int'(cur_x) + ow);
              if (int'(shelf_h) < oh) shelf_h = 13'(oh);
              fits = 1'b1;
            end
          end else if (int'(cur_y) + int'(shelf_h) + oh <= ah) begin
            // open the next shelf
            cur_y = 13'(int'(cur_y) + int'(shelf_h));
            px = e;
            py = int'(cur_y) + e;
            cur_x = 13'(ow);
            shelf_h = 13'(oh);
            fits = 1'b1;
          end
        end
        if (fits) begin
          slot_x = 12'(px);
          slot_y = 12'(py);
          slot_w = w;
          slot_h = h;
          col_n = '0;
          row_n = '0;
          slot_on = (w != 13'd0) && (h != 13'd0);
          one.placed = 1'b1;
          one.pos_x = 12'(px);
          one.pos_y = 12'(py);
        end
        one.last = 1'b1;
        owed_results.push_back(one);
      end
      OpPixel: begin
        if (slot_on) begin
          work_items++;
          bpp = int'(shadow_bpp);
          if (bpp < 1) bpp = 1;
          if (bpp > 4) bpp = 4;
          keep = (bpp == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * bpp)) - 32'd1);
          hard = (shadow_edge >= EdgeHard);
          c0 = int'(slot_x) + int'(col_n);
          r0 = int'(slot_y) + int'(row_n);
          n = 0;
          // 3x3 neighborhood, top row first; gutter copies only on the border
          for (int dy = -1; dy <= 1; dy++) begin
            if (dy == -1 && !(hard && row_n == 13'd0)) continue;
            if (dy == 1 && !(hard && int'(row_n) + 1 == int'(slot_h))) continue;
            for (int dx = -1; dx <= 1; dx++) begin
              if (dx == -1 && !(hard && col_n == 13'd0)) continue;
              if (dx == 1 && !(hard && int'(col_n) + 1 == int'(slot_w))) continue;
              c = c0 + dx;
              r = r0 + dy;
              if (c < 0 || r < 0 || c >= aw || r >= ah) continue;
              one = '0;
              one.kind = 1'b1;
              one.write_index = 24'(r * aw + c);
              one.write_data = pix & keep;
              owed_results.push_back(one);
              n++;
            end
          end
          if (n > 0) owed_results[owed_results.size() - 1].last = 1'b1;
          col_n = col_n + 13'd1;
          if (col_n >= slot_w) begin
            col_n = '0;
            row_n = row_n + 13'd1;
            if (row_n >= slot_h) slot_on = 1'b0;
          end
        end
      end
      OpReset: begin
        work_items++;
        cur_x = '0;
        cur_y = '0;
        shelf_h = '0;
        slot_on = 1'b0;
      end
      default: begin
        // opcode 3 does nothing
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // input side: one item per call, random gaps, tvalid held across back-to-back items
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] op, input logic [12:0] w, h,
                           input logic [31:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'd0, pix, h, w};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_in++;
    in_flight = 1'b1;
    shelf_predict(op, w, h, pix);
  endtask

  // stop sending, wait for every owed result, then let the block settle
  task automatic hold_until_idle();
    s_axis_tvalid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
    in_flight = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] v);
    if (in_flight) hold_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegAtlasWidth:  shadow_aw = v;
      RegAtlasHeight: shadow_ah = v;
      RegBytes:       shadow_bpp = v[2:0];
      default:        shadow_edge = v[1:0];
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random backpressure, field compare, hang watchdog
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] want, seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      n_err++;
    end
  endtask

  int quiet = 0;

  always @(posedge clk_i) begin : out_side
    res_t seen, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_out++;
      seen.kind        = m_axis_tuser_o[0];
      seen.placed      = m_axis_tdata_o[0];
      seen.pos_x       = m_axis_tdata_o[12:1];
      seen.pos_y       = m_axis_tdata_o[24:13];
      seen.write_index = m_axis_tdata_o[48:25];
      seen.write_data  = m_axis_tdata_o[80:49];
      seen.last        = m_axis_tlast_o;
      if (owed_results.size() == 0) begin
        $error("result item with nothing owed: kind %0d tdata %0h", seen.kind,
               m_axis_tdata_o);
        n_err++;
      end else begin
        want = owed_results.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(seen.kind));
        cmp_field("placed", 32'(want.placed), 32'(seen.placed));
        cmp_field("pos_x", 32'(want.pos_x), 32'(seen.pos_x));
        cmp_field("pos_y", 32'(want.pos_y), 32'(seen.pos_y));
        cmp_field("write_index", 32'(want.write_index), 32'(seen.write_index));
        cmp_field("write_data", want.write_data, seen.write_data);
        cmp_field("last", 32'(want.last), 32'(seen.last));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= idle_pct);

    // any handshake or register write counts as progress
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= StallLimit) begin
      $display("timeout: no handshake for %0d cycles, %0d results owed", quiet,
               owed_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows: a register write or an input item, with the answer typed
  // in where it is obvious
  // ---------------------------------------------------------------------------
  typedef enum logic {RowReg, RowItem} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  sel;     // register index or opcode
    logic [12:0] a;       // register value or rect width
    logic [12:0] b;       // rect height
    logic [31:0] pix;
    logic        typed;   // answer below replaces the shadow's
    logic        placed;
    logic [11:0] px;
    logic [11:0] py;
  } plan_row_t;

  function automatic plan_row_t item_row(logic [1:0] op, logic [12:0] w, h,
                                         logic [31:0] pix);
    plan_row_t row;
    row = '{RowItem, op, w, h, pix, 1'b0, 1'b0, 12'd0, 12'd0};
    return row;
  endfunction

  function automatic plan_row_t ans_row(logic [12:0] w, h, logic placed,
                                        logic [11:0] px, py);
    plan_row_t row;
    row = '{RowItem, OpPlace, w, h, 32'hFFFF_FFFF, 1'b1, placed, px, py};
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [12:0] v);
    plan_row_t row;
    row = '{RowReg, idx, v, 13'd0, 32'd0, 1'b0, 1'b0, 12'd0, 12'd0};
    return row;
  endfunction

  function automatic logic [12:0] pick_dim();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 13'd4096;
    if (roll == 1) return 13'($urandom);
    return 13'($urandom_range(1, 24));
  endfunction

  initial begin : stim
    plan_row_t   plan[$];
    res_t        typed_ans;
    logic [12:0] w, h;
    int          n, pick, goal;
    bit          pressed;

    // reset settings: 256x256, four bytes, no gutter
    plan.push_back(ans_row(13'd2, 13'd1, 1'b1, 12'd0, 12'd0));
    plan.push_back(item_row(OpPixel, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h0000_0000));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h1234_5678));  // slot finished
    plan.push_back(ans_row(13'd0, 13'd5, 1'b1, 12'd2, 12'd0));        // empty rect
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h5555_AAAA));  // no slot opened
    plan.push_back(ans_row(13'h1FFF, 13'h1FFF, 1'b0, 12'd0, 12'd0)); // far too big
    plan.push_back(item_row(OpNone, 13'd7, 13'd7, 32'h0));
    plan.push_back(item_row(OpReset, 13'd0, 13'd0, 32'h0));
    // full-width atlas: cursor lands on 4096 and the next inner corner wraps to 0
    plan.push_back(reg_row(RegAtlasWidth, 13'd4096));
    plan.push_back(ans_row(13'd4096, 13'd1, 1'b1, 12'd0, 12'd0));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'hCAFE_F00D));
    plan.push_back(ans_row(13'd0, 13'd1, 1'b1, 12'd0, 12'd0));       // abandons the slot
    plan.push_back(item_row(OpReset, 13'd0, 13'd0, 32'h0));
    // 3x3 atlas, hard gutter, one byte: a 1x1 rect fills all nine cells
    plan.push_back(reg_row(RegAtlasWidth, 13'd3));
    plan.push_back(reg_row(RegAtlasHeight, 13'd3));
    plan.push_back(reg_row(RegBytes, 13'd1));
    plan.push_back(reg_row(RegEdgeMode, 13'(EdgeHard)));
    plan.push_back(ans_row(13'd1, 13'd1, 1'b1, 12'd1, 12'd1));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'hA5A5_A5A5));
    plan.push_back(ans_row(13'd1, 13'd1, 1'b0, 12'd0, 12'd0));       // no room left
    // out-of-range sizes and byte count, edge mode three
    plan.push_back(reg_row(RegAtlasWidth, 13'd0));
    plan.push_back(reg_row(RegAtlasHeight, 13'h1FFF));
    plan.push_back(reg_row(RegBytes, 13'd0));
    plan.push_back(reg_row(RegEdgeMode, 13'(EdgeBoth)));
    plan.push_back(ans_row(13'd0, 13'd0, 1'b0, 12'd0, 12'd0));       // gutter wider than 1
    plan.push_back(reg_row(RegAtlasWidth, 13'd16));
    plan.push_back(reg_row(RegAtlasHeight, 13'd16));
    plan.push_back(reg_row(RegBytes, 13'd7));
    plan.push_back(item_row(OpReset, 13'd0, 13'd0, 32'h0));
    plan.push_back(ans_row(13'd2, 13'd2, 1'b1, 12'd1, 12'd1));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h1111_1111));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h2222_2222));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h3333_3333));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h4444_4444));
    // transparent gutter, then the atlas shrinks under an open slot
    plan.push_back(reg_row(RegEdgeMode, 13'(EdgeClear)));
    plan.push_back(ans_row(13'd1, 13'd2, 1'b1, 12'd5, 12'd1));
    plan.push_back(reg_row(RegAtlasWidth, 13'd5));
    plan.push_back(reg_row(RegEdgeMode, 13'(EdgeHard)));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'h0BAD_CAFE));  // only left gutter fits
    plan.push_back(reg_row(RegAtlasWidth, 13'd4));
    plan.push_back(item_row(OpPixel, 13'd0, 13'd0, 32'hDEAD_BEEF));  // everything dropped

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowReg) begin
        write_reg(plan[i].sel, plan[i].a);
      end else begin
        push_item(plan[i].sel, plan[i].a, plan[i].b, plan[i].pix);
        if (plan[i].typed) begin
          typed_ans = '0;
          typed_ans.placed = plan[i].placed;
          typed_ans.pos_x = plan[i].px;
          typed_ans.pos_y = plan[i].py;
          typed_ans.last = 1'b1;
          owed_results[owed_results.size() - 1] = typed_ans;
        end
      end
    end

    // random phases: fresh settings each, mostly place-then-stream sequences
    pressed = 1'b0;
    for (int p = 0; p < RandPhases; p++) begin
      idle_pct = (p == 2) ? 0 : 31;  // one phase runs flat out on both sides
      write_reg(RegAtlasWidth, pick_dim());
      write_reg(RegAtlasHeight, pick_dim());
      write_reg(RegBytes, 13'($urandom_range(0, 7)));
      write_reg(RegEdgeMode, 13'($urandom_range(0, 3)));
      goal = work_items + PhaseItems;
      while (work_items < goal) begin
        pick = $urandom_range(99);
        if (pick < 68) begin
          w = ($urandom_range(99) < 10) ? 13'($urandom) : 13'($urandom_range(0, 5));
          h = ($urandom_range(99) < 10) ? 13'($urandom) : 13'($urandom_range(0, 5));
          push_item(OpPlace, w, h, $urandom);
          if (slot_on) begin
            // stream the slot, sometimes cut short so the next place abandons it
            n = int'(slot_w) * int'(slot_h);
            if (n > 48 || $urandom_range(99) < 15) n = $urandom_range(0, (n > 48) ? 48 : n);
            repeat (n) push_item(OpPixel, 13'($urandom), 13'($urandom), $urandom);
          end
        end else if (pick < 80) begin
          push_item(OpPixel, 13'($urandom), 13'($urandom), $urandom);
        end else if (pick < 90) begin
          push_item(OpReset, 13'($urandom), 13'($urandom), $urandom);
        end else begin
          push_item(OpNone, 13'($urandom), 13'($urandom), $urandom);
        end
        // once, the sender waits for the block to catch up mid-phase
        if (p == 4 && !pressed && work_items >= goal - PhaseItems / 2) begin
          hold_until_idle();
          pressed = 1'b1;
        end
      end
    end

    hold_until_idle();
    $display("ran %0d input items and checked %0d result items", n_in, n_out);
    $display("directed corners plus %0d random settings of size, bytes and gutter",
             RandPhases);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
